@@ rtl/assert_macros.svh @@
// Assertion macros used by the top level of the varint prefix encoder.
// Holds no other dependencies; the bodies are empty when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// cond must hold on every clock edge outside reset
`define VPE_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");

// cons must hold on the same edge as ante
`define VPE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// cons must hold on the edge after ante
`define VPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define VPE_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define VPE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define VPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/vpe_pkg.sv @@
// Shared types and constants of the varint prefix encoder.
// No dependencies; used by the front, queue, back and top files.
`timescale 1ns / 1ps
`default_nettype none

package vpe_pkg;

	localparam int VALUE_W    = 64;
	localparam int BYTE_W     = 8;
	localparam int LEN_W      = 4;
	localparam int SPACE_W    = 4;
	localparam int MAX_PAYLD  = VALUE_W / BYTE_W;

	// one classified item, as the back part needs it
	typedef struct packed {
		logic [VALUE_W-1:0] data;     // value itself when len is 1, else value - base
		logic [LEN_W-1:0]   len;      // total encoded length, 1 to 9
		logic               no_room;
	} qentry_t;

endpackage

`default_nettype wire

@@ rtl/vpe_front.sv @@
// Front part: accepts input beats, zigzag maps in signed mode, classifies length and room.
// Depends on vpe_pkg; pushes classified entries into vpe_queue.
`timescale 1ns / 1ps
`default_nettype none

module vpe_front #(
	parameter int BASE_THRESHOLD = 248
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          signed_mode,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [vpe_pkg::VALUE_W-1:0]   value,
	input  wire logic [vpe_pkg::SPACE_W-1:0]   space_available,
	output logic                               push_valid,
	input  wire logic                          push_ready,
	output vpe_pkg::qentry_t                   push_entry
);

	localparam logic [vpe_pkg::VALUE_W-1:0] BASE = vpe_pkg::VALUE_W'(BASE_THRESHOLD);

	logic                          valid_s1;
	logic [vpe_pkg::VALUE_W-1:0]   v_s1;
	logic [vpe_pkg::SPACE_W-1:0]   space_s1;

	logic [vpe_pkg::VALUE_W-1:0]   v_dbl;
	logic [vpe_pkg::VALUE_W-1:0]   v_map;
	logic [vpe_pkg::VALUE_W-1:0]   diff;
	logic                          is_short;
	logic [vpe_pkg::LEN_W-1:0]     nb;
	logic [vpe_pkg::LEN_W-1:0]     len;

	assign in_ready = !valid_s1 || push_ready;

	// zigzag: complement of v<<1 for negative inputs
	assign v_dbl = {value[vpe_pkg::VALUE_W-2:0], 1'b0};
	assign v_map = (signed_mode && value[vpe_pkg::VALUE_W-1]) ? ~v_dbl
	             : (signed_mode ? v_dbl : value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			v_s1     <= v_map;
			space_s1 <= space_available;
		end
	end

	assign is_short = v_s1 < BASE;
	assign diff     = v_s1 - BASE;

	// fewest big-endian bytes that hold diff, at least one
	always_comb begin
		nb = vpe_pkg::LEN_W'(1);
		for (int n = 1; n < vpe_pkg::MAX_PAYLD; n++) begin
			if ((diff >> (vpe_pkg::BYTE_W * n)) != '0) begin
				nb = vpe_pkg::LEN_W'(n + 1);
			end
		end
	end

	assign len = is_short ? vpe_pkg::LEN_W'(1) : nb + vpe_pkg::LEN_W'(1);

	assign push_valid         = valid_s1;
	assign push_entry.data    = is_short ? v_s1 : diff;
	assign push_entry.len     = len;
	assign push_entry.no_room = space_s1 < len;

endmodule

`default_nettype wire

@@ rtl/vpe_queue.sv @@
// Two-entry shift queue between the front and back parts.
// Depends on vpe_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module vpe_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push_valid,
	output logic                   push_ready,
	input  wire vpe_pkg::qentry_t  push_entry,
	output logic                   pop_valid,
	input  wire logic              pop_ready,
	output vpe_pkg::qentry_t       pop_entry
);

	logic [1:0]        count_q;
	vpe_pkg::qentry_t  ent0_q;
	vpe_pkg::qentry_t  ent1_q;
	logic              push;
	logic              pop;
	logic              to_head;

	assign push_ready = count_q != 2'd2;
	assign pop_valid  = count_q != 2'd0;
	assign pop_entry  = ent0_q;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign to_head    = count_q == 2'd0 || (pop && count_q == 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (push && !pop) begin
			count_q <= count_q + 2'd1;
		end else if (pop && !push) begin
			count_q <= count_q - 2'd1;
		end
	end

	// head is always ent0; a pop shifts the tail forward
	always_ff @(posedge clk) begin
		if (push && to_head) begin
			ent0_q <= push_entry;
		end else if (pop) begin
			ent0_q <= ent1_q;
		end
		if (push && !to_head) begin
			ent1_q <= push_entry;
		end
	end

endmodule

`default_nettype wire

@@ rtl/vpe_back.sv @@
// Back part: turns queue entries into byte beats behind an output register.
// Depends on vpe_pkg; pops entries from vpe_queue.
`timescale 1ns / 1ps
`default_nettype none

module vpe_back #(
	parameter int BASE_THRESHOLD = 248
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          pop_valid,
	output logic                               pop_ready,
	input  wire vpe_pkg::qentry_t              pop_entry,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [vpe_pkg::BYTE_W-1:0]         out_byte,
	output logic                               last,
	output logic                               no_room,
	output logic [vpe_pkg::LEN_W-1:0]          total_length
);

	logic                          busy_q;
	logic [vpe_pkg::LEN_W-1:0]     cnt_q;
	logic [vpe_pkg::LEN_W-1:0]     run_len_q;
	logic [vpe_pkg::VALUE_W-1:0]   sh_q;

	logic                          out_valid_q;
	logic [vpe_pkg::BYTE_W-1:0]    out_byte_q;
	logic                          last_q;
	logic                          no_room_q;
	logic [vpe_pkg::LEN_W-1:0]     len_q;

	logic                          adv;
	logic                          pop;
	logic                          load;
	logic [vpe_pkg::LEN_W-1:0]     nb;
	logic [2:0]                    lead;
	logic [vpe_pkg::VALUE_W-1:0]   aligned;
	logic [vpe_pkg::BYTE_W-1:0]    hdr;

	logic                          b_valid;
	logic [vpe_pkg::BYTE_W-1:0]    b_byte;
	logic                          b_last;
	logic                          b_no_room;
	logic [vpe_pkg::LEN_W-1:0]     b_len;

	assign adv       = !out_valid_q || out_ready;
	assign pop_ready = adv && !busy_q;
	assign pop       = pop_valid && pop_ready;
	assign load      = pop && !pop_entry.no_room && pop_entry.len != vpe_pkg::LEN_W'(1);

	// left-align the payload so its top byte goes first
	assign nb      = pop_entry.len - vpe_pkg::LEN_W'(1);
	assign lead    = 3'(vpe_pkg::LEN_W'(vpe_pkg::MAX_PAYLD) - nb);
	assign aligned = pop_entry.data << {lead, 3'b000};
	assign hdr     = vpe_pkg::BYTE_W'(BASE_THRESHOLD) + {4'd0, pop_entry.len} - 8'd2;

	always_comb begin
		b_valid   = busy_q || pop_valid;
		b_byte    = hdr;
		b_last    = 1'b0;
		b_no_room = 1'b0;
		b_len     = pop_entry.len;
		if (busy_q) begin
			b_byte = sh_q[vpe_pkg::VALUE_W-1 -: vpe_pkg::BYTE_W];
			b_last = cnt_q == vpe_pkg::LEN_W'(1);
			b_len  = run_len_q;
		end else if (pop_entry.no_room) begin
			b_byte    = '0;
			b_last    = 1'b1;
			b_no_room = 1'b1;
		end else if (pop_entry.len == vpe_pkg::LEN_W'(1)) begin
			b_byte = pop_entry.data[vpe_pkg::BYTE_W-1:0];
			b_last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= b_valid;
			end
			if (load) begin
				busy_q <= 1'b1;
				cnt_q  <= nb;
			end else if (busy_q && adv) begin
				busy_q <= cnt_q != vpe_pkg::LEN_W'(1);
				cnt_q  <= cnt_q - vpe_pkg::LEN_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q <= b_byte;
			last_q     <= b_last;
			no_room_q  <= b_no_room;
			len_q      <= b_len;
		end
		if (load) begin
			sh_q      <= aligned;
			run_len_q <= pop_entry.len;
		end else if (busy_q && adv) begin
			sh_q <= sh_q << vpe_pkg::BYTE_W;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign last         = last_q;
	assign no_room      = no_room_q;
	assign total_length = len_q;

endmodule

`default_nettype wire

@@ rtl/varint_prefix_encoder_top.sv @@
// The first byte of a value passes the front register, the two-entry queue and
// the back output register. Throughput: one output beat per cycle while out_ready
// is high; a value gives len beats (1 to 9), a no-room value one zero beat;
// input beats keep flowing through the front stage and two-entry queue meanwhile.
// Reset: arst_n clears all control state and signed_mode; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module varint_prefix_encoder_top #(
	parameter int BASE_THRESHOLD = 248
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic                          cfg_wr_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [vpe_pkg::VALUE_W-1:0]   value,
	input  wire logic [vpe_pkg::SPACE_W-1:0]   space_available,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [vpe_pkg::BYTE_W-1:0]         out_byte,
	output logic                               last,
	output logic                               no_room,
	output logic [vpe_pkg::LEN_W-1:0]          total_length
);

	logic              signed_mode_q;
	logic              push_valid;
	logic              push_ready;
	vpe_pkg::qentry_t  push_entry;
	logic              pop_valid;
	logic              pop_ready;
	vpe_pkg::qentry_t  pop_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_mode_q <= 1'b0;
		end else if (cfg_wr_en) begin
			signed_mode_q <= cfg_wr_data;
		end
	end

	vpe_front #(
		.BASE_THRESHOLD (BASE_THRESHOLD)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.signed_mode     (signed_mode_q),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.value           (value),
		.space_available (space_available),
		.push_valid      (push_valid),
		.push_ready      (push_ready),
		.push_entry      (push_entry)
	);

	vpe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	vpe_back #(
		.BASE_THRESHOLD (BASE_THRESHOLD)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_entry    (pop_entry),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.last         (last),
		.no_room      (no_room),
		.total_length (total_length)
	);

	// a no-room beat is a lone zero byte
	`VPE_ASSERT_IMPL(a_noroom_lone, clk, arst_n, out_valid && no_room, last && out_byte == 8'd0)
	// only a multi-byte run has beats that are not last
	`VPE_ASSERT_IMPL(a_mid_run, clk, arst_n, out_valid && !last, !no_room && total_length > 4'd1)
	`VPE_ASSERT_IMPL(a_single, clk, arst_n, out_valid && total_length == 4'd1, last)
	// a mode write takes effect at the next edge
	`VPE_ASSERT_NEXT(a_cfg, clk, arst_n, cfg_wr_en, signed_mode_q == $past(cfg_wr_data))

endmodule

`default_nettype wire
